[rtl/core/label_interior_pixel_classifier_defines.svh]
// Assertion macros for the label interior pixel classifier.
// Included by the top level to check its own logic; depends on nothing.
`ifndef LABEL_INTERIOR_PIXEL_CLASSIFIER_DEFINES_SVH
`define LABEL_INTERIOR_PIXEL_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LIPC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked outside reset.
`define LIPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LIPC_ASSERT_NOW(name, clk, rst, ante, cons, msg)
`define LIPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/lipc_pkg.sv]
// Shared types and constants for the label interior pixel classifier.
// Used by the sequencer, top level and testbench; depends on nothing.
package lipc_pkg;

   // Label plane geometry; an entry is addressed row * MAX_WIDTH + col.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_MARGIN = 7;
   localparam int COORD_W    = 8;
   localparam int SIZE_W     = 9;
   localparam int MARGIN_W   = 3;
   localparam int LABEL_W    = 2;
   localparam int CLASS_W    = 2;
   localparam int INDEX_W    = 2;
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   // Window counter runs 0 .. 2 * MAX_MARGIN.
   localparam int SPAN_W     = MARGIN_W + 1;
   // Signed window coordinate: covers -MAX_MARGIN .. 255 + MAX_MARGIN.
   localparam int SCOORD_W   = COORD_W + 3;

   // Label codes as stored.
   localparam logic [LABEL_W-1:0] LABEL_ZERO = 2'd0;
   localparam logic [LABEL_W-1:0] LABEL_ONE  = 2'd1;

   // Request actions.
   typedef enum logic {
      ACTION_WRITE    = 1'b0,
      ACTION_CLASSIFY = 1'b1
   } action_type;

   // Result classes.
   typedef enum logic [CLASS_W-1:0] {
      CLASS_SKIPPED  = 2'd0,
      CLASS_POSITIVE = 2'd1,
      CLASS_NEGATIVE = 2'd2,
      CLASS_REJECTED = 2'd3
   } pixel_class_type;

   // Configuration register indexes.
   typedef enum logic [INDEX_W-1:0] {
      REG_PLANE_WIDTH     = 2'd0,
      REG_PLANE_HEIGHT    = 2'd1,
      REG_POSITIVE_MARGIN = 2'd2,
      REG_NEGATIVE_MARGIN = 2'd3
   } reg_index_type;

   // Scan sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_SCAN,
      ST_RESULT
   } scan_state_type;

   // Active configuration; sizes are kept as the last valid index.
   typedef struct packed {
      logic [COORD_W-1:0]  width_m1;
      logic [COORD_W-1:0]  height_m1;
      logic [MARGIN_W-1:0] margin_one;
      logic [MARGIN_W-1:0] margin_zero;
   } cfg_type;

   // Query handed from the top level to the sequencer.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               care;
   } query_type;

   // Read request from the sequencer to the label memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   // Sequencer status back to the top level.
   typedef struct packed {
      logic            busy;
      logic            done;
      pixel_class_type pixel_class;
   } scan_status_type;

endpackage

[rtl/core/lipc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the label plane; depends on nothing.
module lipc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lipc_scan.sv]
// Window scan sequencer: reads the center label, then checks the clamped
// window one label per cycle to the first mismatch. Depends on lipc_pkg.
module lipc_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  lipc_pkg::cfg_type        cfg,
   input  logic                     start,
   input  lipc_pkg::query_type      query,
   input  logic                     ack,
   input  logic [lipc_pkg::LABEL_W-1:0] rd_data,
   output lipc_pkg::mem_rd_type     mem_rd,
   output lipc_pkg::scan_status_type status
);

   import lipc_pkg::*;

   scan_state_type      state_ff, state_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic [COORD_W-1:0]  col_ff, col_in;
   logic                want_one_ff, want_one_in;
   logic [MARGIN_W-1:0] radius_ff, radius_in;
   logic [SPAN_W-1:0]   i_ff, i_in;
   logic [SPAN_W-1:0]   j_ff, j_in;
   logic                issued_ff, issued_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                cmp_last_ff, cmp_last_in;
   pixel_class_type     class_ff, class_in;

   logic                skip;
   logic [SPAN_W-1:0]   span_end;
   logic [LABEL_W-1:0]  want_code;
   logic                mismatch;
   logic signed [SCOORD_W-1:0] row_raw;
   logic signed [SCOORD_W-1:0] col_raw;
   logic [COORD_W-1:0]  row_clamp;
   logic [COORD_W-1:0]  col_clamp;

   // A query without care or outside the plane in use is skipped at once.
   assign skip = !query.care || (query.row > cfg.height_m1) || (query.col > cfg.width_m1);

   assign span_end  = {radius_ff, 1'b0};
   assign want_code = want_one_ff ? LABEL_ONE : LABEL_ZERO;
   assign mismatch  = cmp_valid_ff && (rd_data != want_code);

   // Window coordinates, clamped to the plane edges.
   assign row_raw = $signed({3'b000, row_ff}) + $signed({{(SCOORD_W-SPAN_W){1'b0}}, i_ff})
                  - $signed({{(SCOORD_W-MARGIN_W){1'b0}}, radius_ff});
   assign col_raw = $signed({3'b000, col_ff}) + $signed({{(SCOORD_W-SPAN_W){1'b0}}, j_ff})
                  - $signed({{(SCOORD_W-MARGIN_W){1'b0}}, radius_ff});

   always_comb begin
      priority if (row_raw < 0) begin
         row_clamp = '0;
      end else if (row_raw > $signed({3'b000, cfg.height_m1})) begin
         row_clamp = cfg.height_m1;
      end else begin
         row_clamp = row_raw[COORD_W-1:0];
      end
      priority if (col_raw < 0) begin
         col_clamp = '0;
      end else if (col_raw > $signed({3'b000, cfg.width_m1})) begin
         col_clamp = cfg.width_m1;
      end else begin
         col_clamp = col_raw[COORD_W-1:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = skip ? ST_RESULT : ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (mismatch || (cmp_valid_ff && cmp_last_ff)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      want_one_in  = want_one_ff;
      radius_in    = radius_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      issued_in    = issued_ff;
      cmp_valid_in = 1'b0;
      cmp_last_in  = 1'b0;
      class_in     = class_ff;
      mem_rd.en    = 1'b0;
      mem_rd.addr  = {row_ff, col_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               row_in   = query.row;
               col_in   = query.col;
               class_in = CLASS_SKIPPED;
            end
         end
         ST_LOOKUP: begin
            // Center label decides which window test applies.
            mem_rd.en = 1'b1;
         end
         ST_DECIDE: begin
            want_one_in = (rd_data != LABEL_ZERO);
            radius_in   = (rd_data != LABEL_ZERO) ? cfg.margin_one : cfg.margin_zero;
            i_in        = '0;
            j_in        = '0;
            issued_in   = 1'b0;
         end
         ST_SCAN: begin
            // One window read per cycle, row by row.
            if (!issued_ff) begin
               mem_rd.en    = 1'b1;
               mem_rd.addr  = {row_clamp, col_clamp};
               cmp_valid_in = 1'b1;
               cmp_last_in  = (i_ff == span_end) && (j_ff == span_end);
               if (j_ff == span_end) begin
                  j_in = '0;
                  if (i_ff == span_end) begin
                     issued_in = 1'b1;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
            // Compare the label read in the previous cycle.
            if (mismatch) begin
               class_in = CLASS_REJECTED;
            end else if (cmp_valid_ff && cmp_last_ff) begin
               class_in = want_one_ff ? CLASS_POSITIVE : CLASS_NEGATIVE;
            end
         end
         ST_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      want_one_ff <= want_one_in;
      radius_ff   <= radius_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      issued_ff   <= issued_in;
      cmp_last_ff <= cmp_last_in;
      class_ff    <= class_in;
   end

   assign status.busy        = (state_ff != ST_IDLE);
   assign status.done        = (state_ff == ST_RESULT);
   assign status.pixel_class = class_ff;

endmodule

[rtl/core/label_interior_pixel_classifier.sv]
// Channel | direction | ports                                      | moves
// req     | in        | req_valid/req_ready, action row col code care | one request word
// rsp     | out       | rsp_valid/rsp_ready, rsp_pixel_class        | one class word
// csr     | in        | csr_write, csr_index, csr_data              | one register write
//
// Label writes can be accepted back to back.
// A skipped query goes straight to its result; a scanned query reads the
// window set by the margin of its center label one label at a time via the
// single read port of the label memory, and ends early on the first mismatch.
// Reset clears control and loads the register defaults; the label plane is
// not cleared. A result waits in the output register while the next request
// is accepted; a later query holds its result until that register frees.
//
// Top level of the label interior pixel classifier. Depends on lipc_pkg,
// lipc_ram, lipc_scan and the assertion macro header.
`include "label_interior_pixel_classifier_defines.svh"

module label_interior_pixel_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [lipc_pkg::COORD_W-1:0]  req_row,
   input  logic [lipc_pkg::COORD_W-1:0]  req_col,
   input  logic [lipc_pkg::LABEL_W-1:0]  req_label_code,
   input  logic                          req_care,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lipc_pkg::CLASS_W-1:0]  rsp_pixel_class,
   input  logic                          csr_write,
   input  logic [lipc_pkg::INDEX_W-1:0]  csr_index,
   input  logic [lipc_pkg::SIZE_W-1:0]   csr_data
);

   import lipc_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0]  rsp_class_ff, rsp_class_in;

   logic                req_accept;
   logic                ram_we;
   logic                start;
   logic                rsp_load;
   logic [COORD_W-1:0]  size_m1;
   logic [LABEL_W-1:0]  rd_data;
   query_type           query;
   mem_rd_type          mem_rd;
   scan_status_type     scan_status;

   // Size register value as last valid index: zero acts as one, large saturates.
   always_comb begin
      priority if (csr_data == '0) begin
         size_m1 = '0;
      end else if (csr_data > SIZE_W'(MAX_WIDTH)) begin
         size_m1 = COORD_W'(MAX_WIDTH - 1);
      end else begin
         size_m1 = COORD_W'(csr_data - 1'b1);
      end
   end

   // Configuration writes; the three-bit margin field already stays in range.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_PLANE_WIDTH:     cfg_in.width_m1    = size_m1;
            REG_PLANE_HEIGHT:    cfg_in.height_m1   = size_m1;
            REG_POSITIVE_MARGIN: cfg_in.margin_one  = csr_data[MARGIN_W-1:0];
            REG_NEGATIVE_MARGIN: cfg_in.margin_zero = csr_data[MARGIN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Requests are taken while the sequencer is idle; writes go straight
   // to memory, so a write never overlaps a scan of the same plane.
   assign req_ready  = !scan_status.busy;
   assign req_accept = req_valid && req_ready;
   assign ram_we     = req_accept && (action_type'(req_action) == ACTION_WRITE);
   assign start      = req_accept && (action_type'(req_action) == ACTION_CLASSIFY);

   assign query.row  = req_row;
   assign query.col  = req_col;
   assign query.care = req_care;

   lipc_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (DEPTH)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_label_code),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (rd_data)
   );

   lipc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .start   (start),
      .query   (query),
      .ack     (rsp_load),
      .rd_data (rd_data),
      .mem_rd  (mem_rd),
      .status  (scan_status)
   );

   // Output register: loads a finished class when it is empty or draining.
   assign rsp_load = scan_status.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_class_in = rsp_class_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = scan_status.pixel_class;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_m1    <= COORD_W'(MAX_WIDTH - 1);
         cfg_ff.height_m1   <= COORD_W'(MAX_HEIGHT - 1);
         cfg_ff.margin_one  <= '0;
         cfg_ff.margin_zero <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff             <= cfg_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_class = rsp_class_ff;

   // A label write never lands while a query is being worked on.
   `LIPC_ASSERT_NOW(a_write_idle, clock, reset, ram_we, !scan_status.busy, "label write during scan")
   // An accepted query keeps the sequencer busy in the next cycle.
   `LIPC_ASSERT_NEXT(a_query_busy, clock, reset, start, scan_status.busy, "query not started")
   // A finished class is held while the output register stays full.
   `LIPC_ASSERT_NEXT(a_result_held, clock, reset, scan_status.done && rsp_valid_ff && !rsp_ready, scan_status.done, "finished class dropped")

endmodule

[verif/tb.sv]
// Self-checking testbench for the label interior pixel classifier. Fills a
// corner of the label plane, then checks each class word against a local
// predictor or table. Depends on lipc_pkg, label_interior_pixel_classifier.
module tb;
   import lipc_pkg::*;

   localparam int CYCLE_LIMIT   = 2500000;
   localparam int SETTLE_CYCLES = 256;
   localparam int PHASE_ITEMS   = 80;
   localparam int PHASE_COUNT   = 8;
   // Side of the square corner block written before any query.
   localparam int FILL_SIDE     = 24;

   // Label codes with no name in the package.
   localparam logic [LABEL_W-1:0] LABEL_OTHER = 2'd2;
   localparam logic [LABEL_W-1:0] LABEL_SPARE = 2'd3;

   // Idle profiles, in percent per cycle.
   localparam int IDLE_NONE = 0;
   localparam int IDLE_HIGH = 68;
   localparam int IDLE_BOTH = 23;

   logic                clock;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic                req_action      = ACTION_WRITE;
   logic [COORD_W-1:0]  req_row         = '0;
   logic [COORD_W-1:0]  req_col         = '0;
   logic [LABEL_W-1:0]  req_label_code  = '0;
   logic                req_care        = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [CLASS_W-1:0]  rsp_pixel_class;
   logic                csr_write       = 1'b0;
   logic [INDEX_W-1:0]  csr_index       = REG_PLANE_WIDTH;
   logic [SIZE_W-1:0]   csr_data        = '0;

   // Local copy of the label plane and of the active configuration.
   logic [LABEL_W-1:0]  label_plane [DEPTH];
   bit                  label_written [DEPTH];
   int                  plane_w;
   int                  plane_h;
   int                  margin_one;
   int                  margin_zero;

   pixel_class_type     expected_classes [$];
   int                  errors         = 0;
   int                  cycle_count    = 0;
   int                  send_idle_pct  = IDLE_NONE;
   int                  recv_stall_pct = IDLE_NONE;

   // One row of the directed table; typed rows carry their own class.
   typedef struct {
      action_type          action;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [LABEL_W-1:0]  code;
      logic                care;
      logic                typed;
      pixel_class_type     cls;
   } probe_row_type;

   probe_row_type directed_rows [18];

   label_interior_pixel_classifier DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_label_code  (req_label_code),
      .req_care        (req_care),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_class (rsp_pixel_class),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit, in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // True when every label in the edge-clamped window equals want.
   function automatic bit window_uniform(int r, int c, int radius, logic [LABEL_W-1:0] want);
      int dr;
      int dc;
      int rr;
      int cc;
      for (dr = -radius; dr <= radius; dr++) begin
         rr = r + dr;
         if (rr < 0) rr = 0;
         if (rr > plane_h - 1) rr = plane_h - 1;
         for (dc = -radius; dc <= radius; dc++) begin
            cc = c + dc;
            if (cc < 0) cc = 0;
            if (cc > plane_w - 1) cc = plane_w - 1;
            if (label_plane[ADDR_W'(rr * MAX_WIDTH + cc)] != want) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // True when every entry of the edge-clamped window has been written.
   function automatic bit window_written(int r, int c, int radius);
      int dr;
      int dc;
      int rr;
      int cc;
      for (dr = -radius; dr <= radius; dr++) begin
         rr = r + dr;
         if (rr < 0) rr = 0;
         if (rr > plane_h - 1) rr = plane_h - 1;
         for (dc = -radius; dc <= radius; dc++) begin
            cc = c + dc;
            if (cc < 0) cc = 0;
            if (cc > plane_w - 1) cc = plane_w - 1;
            if (!label_written[ADDR_W'(rr * MAX_WIDTH + cc)]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // True when a query would look at a label that was never written.
   function automatic bit touches_unwritten(logic [COORD_W-1:0] row,
                                            logic [COORD_W-1:0] col,
                                            logic care);
      if (!care || int'(row) >= plane_h || int'(col) >= plane_w) return 1'b0;
      if (!label_written[{row, col}]) return 1'b1;
      if (label_plane[{row, col}] != LABEL_ZERO)
         return !window_written(int'(row), int'(col), margin_one);
      return !window_written(int'(row), int'(col), margin_zero);
   endfunction

   // Class of one query against the current plane and configuration.
   function automatic pixel_class_type predict_class(logic [COORD_W-1:0] row,
                                                     logic [COORD_W-1:0] col,
                                                     logic care);
      if (!care || int'(row) >= plane_h || int'(col) >= plane_w) return CLASS_SKIPPED;
      if (label_plane[{row, col}] != LABEL_ZERO)
         return window_uniform(int'(row), int'(col), margin_one, LABEL_ONE) ? CLASS_POSITIVE
                                                                          : CLASS_REJECTED;
      return window_uniform(int'(row), int'(col), margin_zero, LABEL_ZERO) ? CLASS_NEGATIVE
                                                                         : CLASS_REJECTED;
   endfunction

   function automatic int sat_size(logic [SIZE_W-1:0] value, int limit);
      if (value == 0) return 1;
      if (int'(value) > limit) return limit;
      return int'(value);
   endfunction

   function automatic int sat_margin(logic [SIZE_W-1:0] value);
      if (int'(value[MARGIN_W-1:0]) > MAX_MARGIN) return MAX_MARGIN;
      return int'(value[MARGIN_W-1:0]);
   endfunction

   // Initial corner contents: 6 by 6 tiles of ones and zeros, some speckled.
   function automatic logic [LABEL_W-1:0] fill_code(int r, int c);
      case (((r / 6) + 2 * (c / 6)) % 4)
         0: fill_code = LABEL_ONE;
         1: fill_code = LABEL_ZERO;
         2: fill_code = ((r ^ c) % 11 == 0) ? LABEL_OTHER : LABEL_ONE;
         default: fill_code = ((r + c) % 13 == 0) ? LABEL_ONE : LABEL_ZERO;
      endcase
   endfunction

   // One register write; the port is lowered again after it.
   task automatic write_reg(reg_index_type index, logic [SIZE_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      case (index)
         REG_PLANE_WIDTH:     plane_w     = sat_size(value, MAX_WIDTH);
         REG_PLANE_HEIGHT:    plane_h     = sat_size(value, MAX_HEIGHT);
         REG_POSITIVE_MARGIN: margin_one  = sat_margin(value);
         default:             margin_zero = sat_margin(value);
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Send one request word and record what it should cause once accepted.
   // A query that would look at unwritten labels is sent without care.
   task automatic send_word(action_type action, logic [COORD_W-1:0] row,
                            logic [COORD_W-1:0] col, logic [LABEL_W-1:0] code,
                            logic care, logic typed, pixel_class_type cls);
      int gap;
      logic care_q;
      gap    = 0;
      care_q = care;
      if (action == ACTION_CLASSIFY && touches_unwritten(row, col, care))
         care_q = 1'b0;
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_row        <= row;
      req_col        <= col;
      req_label_code <= code;
      req_care       <= care_q;
      do @(posedge clock); while (!req_ready);
      if (action == ACTION_WRITE) begin
         label_plane[{row, col}]   = code;
         label_written[{row, col}] = 1'b1;
      end else begin
         expected_classes.insert(expected_classes.size(),
                                 typed ? cls : predict_class(row, col, care_q));
      end
   endtask

   // Wait for every expected class word, then for any write still in flight.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_classes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] random_size();
      case ($urandom_range(0, 3))
         0: random_size = SIZE_W'($urandom_range(1, 24));
         1: random_size = SIZE_W'($urandom_range(1, 256));
         2: random_size = SIZE_W'($urandom_range(0, 511));
         default: random_size = SIZE_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Painted squares in the filled corner, queries around them, plus noise.
   task automatic run_phase(int item_target);
      int sent;
      int fr;
      int fc;
      int side;
      int dr;
      int dc;
      int r;
      int c;
      int nq;
      int q;
      int reach;
      logic [LABEL_W-1:0] paint;
      sent  = 0;
      reach = ((margin_one > margin_zero) ? margin_one : margin_zero) + 2;
      while (sent < item_target) begin
         if ($urandom_range(0, 99) < 15) begin
            send_word(action_type'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                      2'($urandom), 1'($urandom), 1'b0, CLASS_SKIPPED);
            sent++;
         end else begin
            fr = $urandom_range(0, ((plane_h < FILL_SIDE) ? plane_h : FILL_SIDE) - 1);
            fc = $urandom_range(0, ((plane_w < FILL_SIDE) ? plane_w : FILL_SIDE) - 1);
            case ($urandom_range(0, 19))
               0: paint = LABEL_OTHER;
               1: paint = LABEL_SPARE;
               2, 3, 4, 5, 6, 7, 8, 9, 10: paint = LABEL_ZERO;
               default: paint = LABEL_ONE;
            endcase
            side = $urandom_range(1, 6);
            for (dr = 0; dr < side; dr++) begin
               for (dc = 0; dc < side; dc++) begin
                  r = fr - side / 2 + dr;
                  c = fc - side / 2 + dc;
                  if (r >= 0 && r <= 255 && c >= 0 && c <= 255) begin
                     send_word(ACTION_WRITE, 8'(r), 8'(c), paint, 1'($urandom),
                               1'b0, CLASS_SKIPPED);
                     sent++;
                  end
               end
            end
            nq = $urandom_range(2, 6);
            for (q = 0; q < nq; q++) begin
               r = fr + $urandom_range(0, 2 * reach) - reach;
               c = fc + $urandom_range(0, 2 * reach) - reach;
               if (r < 0) r = 0;
               if (r > 255) r = 255;
               if (c < 0) c = 0;
               if (c > 255) c = 255;
               send_word(ACTION_CLASSIFY, 8'(r), 8'(c), 2'($urandom),
                         $urandom_range(0, 9) != 0, 1'b0, CLASS_SKIPPED);
               sent++;
            end
         end
      end
   endtask

   // Accept class words and compare each with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      pixel_class_type want;
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_classes.size() == 0) begin
            $display("%0t: pixel_class expected none, actual %0d", $time, rsp_pixel_class);
            errors++;
         end else begin
            want = expected_classes.pop_front();
            if (rsp_pixel_class !== want) begin
               $display("%0t: pixel_class expected %0d, actual %0d",
                        $time, want, rsp_pixel_class);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      int i;
      int p;
      int r;
      int c;
      // Checks under the reset configuration: full plane, both margins zero.
      directed_rows = '{
         '{ACTION_WRITE,    8'd0,   8'd0,   LABEL_ONE,   1'b0, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd0,   8'd0,   LABEL_ZERO,  1'b1, 1'b1, CLASS_POSITIVE},
         '{ACTION_CLASSIFY, 8'd0,   8'd0,   LABEL_SPARE, 1'b0, 1'b1, CLASS_SKIPPED},
         '{ACTION_WRITE,    8'd255, 8'd255, LABEL_OTHER, 1'b1, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd255, 8'd255, LABEL_ZERO,  1'b1, 1'b1, CLASS_REJECTED},
         '{ACTION_WRITE,    8'd255, 8'd0,   LABEL_SPARE, 1'b0, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd255, 8'd0,   LABEL_ONE,   1'b1, 1'b1, CLASS_REJECTED},
         '{ACTION_WRITE,    8'd0,   8'd255, LABEL_ZERO,  1'b1, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd0,   8'd255, LABEL_OTHER, 1'b1, 1'b1, CLASS_NEGATIVE},
         '{ACTION_CLASSIFY, 8'd255, 8'd255, LABEL_ZERO,  1'b0, 1'b1, CLASS_SKIPPED},
         '{ACTION_WRITE,    8'd128, 8'd127, LABEL_ONE,   1'b0, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd128, 8'd127, LABEL_ZERO,  1'b1, 1'b1, CLASS_POSITIVE},
         '{ACTION_WRITE,    8'd127, 8'd128, LABEL_ZERO,  1'b0, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd127, 8'd128, LABEL_ONE,   1'b1, 1'b1, CLASS_NEGATIVE},
         '{ACTION_CLASSIFY, 8'd5,   8'd17,  LABEL_ZERO,  1'b1, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd17,  8'd5,   LABEL_ZERO,  1'b1, 1'b0, CLASS_SKIPPED},
         '{ACTION_WRITE,    8'd17,  8'd5,   LABEL_OTHER, 1'b0, 1'b0, CLASS_SKIPPED},
         '{ACTION_CLASSIFY, 8'd17,  8'd5,   LABEL_ZERO,  1'b1, 1'b1, CLASS_REJECTED}
      };
      plane_w     = MAX_WIDTH;
      plane_h     = MAX_HEIGHT;
      margin_one  = 0;
      margin_zero = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Write the corner block that the queries work around.
      for (i = 0; i < FILL_SIDE * FILL_SIDE; i++) begin
         r = i / FILL_SIDE;
         c = i % FILL_SIDE;
         send_word(ACTION_WRITE, 8'(r), 8'(c), fill_code(r, c), 1'b1,
                   1'b0, CLASS_SKIPPED);
      end

      foreach (directed_rows[k])
         send_word(directed_rows[k].action, directed_rows[k].row, directed_rows[k].col,
                   directed_rows[k].code, directed_rows[k].care, directed_rows[k].typed,
                   directed_rows[k].cls);
      drain();

      // Random phases, each with its own configuration and idle profile.
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               write_reg(REG_PLANE_WIDTH, 9'd256);
               write_reg(REG_PLANE_HEIGHT, 9'd256);
               write_reg(REG_POSITIVE_MARGIN, 9'd7);
               write_reg(REG_NEGATIVE_MARGIN, 9'd7);
            end
            1: begin
               write_reg(REG_NEGATIVE_MARGIN, 9'd7);
               write_reg(REG_POSITIVE_MARGIN, 9'd0);
               write_reg(REG_PLANE_HEIGHT, 9'd1);
               write_reg(REG_PLANE_WIDTH, 9'd1);
            end
            2: begin
               // Zero width acts as one, an oversized height saturates.
               write_reg(REG_PLANE_WIDTH, 9'd0);
               write_reg(REG_PLANE_HEIGHT, 9'd511);
               write_reg(REG_POSITIVE_MARGIN, 9'h1FB);
               write_reg(REG_NEGATIVE_MARGIN, 9'd0);
            end
            3: begin
               write_reg(REG_PLANE_WIDTH, 9'd300);
               write_reg(REG_PLANE_HEIGHT, 9'd0);
               write_reg(REG_POSITIVE_MARGIN, 9'd7);
               write_reg(REG_NEGATIVE_MARGIN, 9'h100);
            end
            default: begin
               write_reg(REG_PLANE_WIDTH, random_size());
               write_reg(REG_PLANE_HEIGHT, random_size());
               write_reg(REG_POSITIVE_MARGIN, 9'($urandom));
               write_reg(REG_NEGATIVE_MARGIN, 9'($urandom));
            end
         endcase
         case (p % 4)
            0: begin
               send_idle_pct  = IDLE_NONE;
               recv_stall_pct = IDLE_NONE;
            end
            1: begin
               send_idle_pct  = IDLE_HIGH;
               recv_stall_pct = IDLE_NONE;
            end
            2: begin
               send_idle_pct  = IDLE_NONE;
               recv_stall_pct = IDLE_HIGH;
            end
            default: begin
               send_idle_pct  = IDLE_BOTH;
               recv_stall_pct = IDLE_BOTH;
            end
         endcase
         run_phase(PHASE_ITEMS);
         drain();
      end

      if (errors == 0 && expected_classes.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/lipc_pkg.sv
rtl/core/lipc_ram.sv
rtl/core/lipc_scan.sv
rtl/core/label_interior_pixel_classifier.sv
verif/tb.sv
